// File: rtl/core/binary_to_decimal_ascii_unit_defines.svh
// Assertion macros used by the decimal conversion top level.
`ifndef BINARY_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Check that a property holds on every rising clock edge outside reset.
`define B2DA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Check that a condition in one cycle is followed by another in the next cycle.
`define B2DA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   `B2DA_ASSERT(lbl, clk, rst, (ante) |=> (cons))
`else
`define B2DA_ASSERT(lbl, clk, rst, prop)
`define B2DA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: rtl/core/b2da_pkg.sv
// Shared types and constants for the binary to decimal ASCII converter.
`default_nettype none
package b2da_pkg;

   localparam int VALUE_W  = 32;
   localparam int DIGITS   = 10;
   localparam int BCD_W    = 4 * DIGITS;
   localparam int CNT_W    = $clog2(VALUE_W + 1);
   localparam int LEFT_W   = $clog2(DIGITS + 1);
   localparam int CHAR_W   = 6;

   localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'(3 << 4);
   localparam logic [CHAR_W-1:0] ASCII_NINE = 6'((3 << 4) + 9);
   localparam logic [3:0]        RADIX      = 4'd10;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_EMIT
   } state_type;

   // Status from the shift-and-add converter
   typedef struct packed {
      logic busy;
      logic done;
   } dab_stat_type;

endpackage
`default_nettype wire

// File: rtl/core/b2da_dabble.sv
// Bit-serial shift-and-add-3 converter from binary to packed BCD.
`default_nettype none
module b2da_dabble (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [b2da_pkg::VALUE_W-1:0]   value,
   output b2da_pkg::dab_stat_type              stat,
   output logic [b2da_pkg::BCD_W-1:0]          bcd
);

   logic [b2da_pkg::VALUE_W-1:0] bin_ff, bin_in;
   logic [b2da_pkg::BCD_W-1:0]   bcd_ff, bcd_in, adj;
   logic [b2da_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;

   // Add three to every digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < b2da_pkg::DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= (b2da_pkg::RADIX >> 1)) begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   // Shift one binary bit into the BCD digits per cycle
   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         bin_in  = value;
         bcd_in  = '0;
         cnt_in  = b2da_pkg::CNT_W'(b2da_pkg::VALUE_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         {bcd_in, bin_in} = {adj[b2da_pkg::BCD_W-2:0], bin_ff, 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == b2da_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign bcd       = bcd_ff;

endmodule
`default_nettype wire

// File: rtl/core/binary_to_decimal_ascii_unit.sv
// Top level: converts a 32-bit number into a run of ASCII decimal digits.
// A request is taken in idle and runs through the 32-step bit-serial shift-and-add-3 loop;
// leading zeros are then dropped, then one digit per cycle goes out when the result side is ready.
// All ten digit slots (skipped zeros too) are walked, and a new request is taken only after
// the last digit of the previous one has been loaded into the output register.
// Reset: synchronous, active high; clears the controller and the output valid.
`default_nettype none
`include "binary_to_decimal_ascii_unit_defines.svh"
module binary_to_decimal_ascii_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [5:0] digit_char, [7:6] zero
   output logic             rsp_tlast    // last_digit
);

   b2da_pkg::state_type            state_ff, state_in;
   b2da_pkg::dab_stat_type         dab_stat;
   logic [b2da_pkg::BCD_W-1:0]     dab_bcd;
   logic [b2da_pkg::BCD_W-1:0]     dig_ff, dig_in;
   logic [b2da_pkg::LEFT_W-1:0]    left_ff, left_in;
   logic                           lead_ff, lead_in;
   logic                           out_vld_ff, out_vld_in;
   logic [b2da_pkg::CHAR_W-1:0]    out_char_ff, out_char_in;
   logic                           out_last_ff, out_last_in;
   logic [3:0]                     top_dig;
   logic                           skip_zero, slot_free;
   logic                           dab_start, shift_en, load_out;

   b2da_dabble u_dabble (
      .clock (clock),
      .reset (reset),
      .start (dab_start),
      .value (req_tdata),
      .stat  (dab_stat),
      .bcd   (dab_bcd)
   );

   assign top_dig   = dig_ff[b2da_pkg::BCD_W-1 -: 4];
   assign skip_zero = lead_ff && (top_dig == 4'd0) && (left_ff != b2da_pkg::LEFT_W'(1));
   assign slot_free = !out_vld_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         b2da_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = b2da_pkg::ST_CONV;
         end
         b2da_pkg::ST_CONV: begin
            if (dab_stat.done) state_in = b2da_pkg::ST_EMIT;
         end
         b2da_pkg::ST_EMIT: begin
            if (!skip_zero && slot_free && left_ff == b2da_pkg::LEFT_W'(1)) begin
               state_in = b2da_pkg::ST_IDLE;
            end
         end
         default: state_in = b2da_pkg::ST_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      req_tready = 1'b0;
      dab_start  = 1'b0;
      shift_en   = 1'b0;
      load_out   = 1'b0;
      case (state_ff)
         b2da_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            dab_start  = req_tvalid;
         end
         b2da_pkg::ST_EMIT: begin
            if (skip_zero) begin
               shift_en = 1'b1;
            end else if (slot_free) begin
               shift_en = 1'b1;
               load_out = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Load the digits, drop leading zeros, advance one digit per emit
   always_comb begin
      dig_in  = dig_ff;
      left_in = left_ff;
      lead_in = lead_ff;
      if (dab_stat.done) begin
         dig_in  = dab_bcd;
         left_in = b2da_pkg::LEFT_W'(b2da_pkg::DIGITS);
         lead_in = 1'b1;
      end else if (shift_en) begin
         dig_in  = {dig_ff[b2da_pkg::BCD_W-5:0], 4'd0};
         left_in = left_ff - 1'b1;
         if (load_out) lead_in = 1'b0;
      end
   end

   // Hold the result in an output register until taken
   always_comb begin
      out_vld_in  = out_vld_ff;
      out_char_in = out_char_ff;
      out_last_in = out_last_ff;
      if (load_out) begin
         out_vld_in  = 1'b1;
         out_char_in = b2da_pkg::ASCII_ZERO | {2'b00, top_dig};
         out_last_in = (left_ff == b2da_pkg::LEFT_W'(1));
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= b2da_pkg::ST_IDLE;
         out_vld_ff <= 1'b0;
         left_ff    <= '0;
         lead_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
         left_ff    <= left_in;
         lead_ff    <= lead_in;
      end
      dig_ff      <= dig_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {2'b00, out_char_ff};
   assign rsp_tlast  = out_last_ff;

   `B2DA_ASSERT(a_char_range, clock, reset,
      !out_vld_ff || (out_char_ff >= b2da_pkg::ASCII_ZERO && out_char_ff <= b2da_pkg::ASCII_NINE))
   `B2DA_ASSERT(a_conv_owned, clock, reset,
      !(dab_stat.busy || dab_stat.done) || state_ff == b2da_pkg::ST_CONV)
   `B2DA_ASSERT(a_emit_left, clock, reset,
      state_ff != b2da_pkg::ST_EMIT || left_ff != '0)
   `B2DA_ASSERT_NEXT(a_last_idle, clock, reset,
      load_out && left_ff == b2da_pkg::LEFT_W'(1), state_ff == b2da_pkg::ST_IDLE && out_last_ff)

endmodule
`default_nettype wire

// File: sim/binary_to_decimal_ascii_checker.sv
// Checker for the decimal ASCII converter: predicts digit runs and compares responses.
`timescale 1ns / 1ps
module binary_to_decimal_ascii_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [7:0]  rsp_tdata,   // [5:0] digit_char, [7:6] zero
   input  wire logic        rsp_tlast,   // last_digit
   output int               error_count,
   output int               pending_digits,
   output int               checked_digits
);

   typedef struct packed {
      logic [b2da_pkg::CHAR_W-1:0] digit_char;
      logic                        last_digit;
   } decimal_char_type;

   decimal_char_type expected_digits[$];
   int               mismatches = 0;
   int               digits_seen = 0;

   // Split a number into decimal digits, most significant first, no leading zeros
   function automatic void queue_decimal_digits(input logic [b2da_pkg::VALUE_W-1:0] number);
      logic [3:0]                   rev_digits [b2da_pkg::DIGITS];
      logic [b2da_pkg::VALUE_W-1:0] rest;
      int                           count;
      rest  = number;
      count = 0;
      do begin
         rev_digits[count] = 4'(rest % b2da_pkg::RADIX);
         rest              = rest / b2da_pkg::RADIX;
         count++;
      end while (rest != '0 && count < b2da_pkg::DIGITS);
      for (int k = count - 1; k >= 0; k--) begin
         expected_digits.push_back('{
            digit_char: b2da_pkg::ASCII_ZERO | b2da_pkg::CHAR_W'(rev_digits[k]),
            last_digit: (k == 0)});
      end
   endfunction

   // Compare each response against the oldest prediction, then queue new requests
   always @(posedge clock) begin
      decimal_char_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            digits_seen++;
            if (expected_digits.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("[%0t] unexpected digit: tdata=%02h tlast=%0b",
                           $time, rsp_tdata, rsp_tlast);
            end else begin
               want = expected_digits.pop_front();
               if (rsp_tdata[5:0] !== want.digit_char || rsp_tdata[7:6] !== 2'b00 ||
                   rsp_tlast !== want.last_digit) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"[%0t] digit mismatch: expected tdata=%02h tlast=%0b, ",
                               "got tdata=%02h tlast=%0b"},
                              $time, {2'b00, want.digit_char}, want.last_digit,
                              rsp_tdata, rsp_tlast);
               end
            end
         end
         if (req_tvalid && req_tready)
            queue_decimal_digits(req_tdata);
      end
      error_count    <= mismatches;
      pending_digits <= expected_digits.size();
      checked_digits <= digits_seen;
   end

endmodule

// File: sim/testbench.sv
// Testbench top for the decimal ASCII converter: stimulus, pacing and verdict.
`timescale 1ns / 1ps
module testbench;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 60;
   localparam int RANDOM_PER_PHASE = 86;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;

   int error_count;
   int pending_digits;
   int checked_digits;
   int send_idle_pct = 33;
   int recv_idle_pct = 70;
   int numbers_sent = 0;
   int quiet_cycles = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   binary_to_decimal_ascii_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   binary_to_decimal_ascii_checker digit_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .error_count    (error_count),
      .pending_digits (pending_digits),
      .checked_digits (checked_digits)
   );

   // Stall the response side at random
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Abort when neither side has moved for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired after %0d quiet cycles", quiet_cycles);
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one number, with a random gap before it, and hold until accepted
   task automatic send_number(input logic [31:0] number);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= number;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      numbers_sent++;
   endtask

   // Hold off the request side until every predicted digit has come back
   task automatic drain_digits();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_digits != 0) @(posedge clock);
   endtask

   // Pick a number: full range, a chosen digit count, small, or near a power of ten
   function automatic logic [31:0] pick_number();
      longint unsigned lo;
      longint unsigned hi;
      int              width;
      int              kind;
      kind = $urandom_range(0, 9);
      if (kind <= 3)
         return $urandom;
      width = $urandom_range(1, 10);
      lo = 1;
      for (int i = 1; i < width; i++) lo = lo * 10;
      hi = (width == 10) ? 64'hFFFF_FFFF : lo * 10 - 1;
      if (kind <= 7)
         return 32'($urandom_range(32'(hi), (width == 1) ? 0 : 32'(lo)));
      if (kind == 8)
         return 32'($urandom_range(99, 0));
      return 32'(lo + $urandom_range(1, 0) - $urandom_range(1, 0) * ((lo > 1) ? 2 : 0));
   endfunction

   initial begin
      logic [31:0] directed_values [22];
      directed_values = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd101,
                          32'd65535, 32'd123456789, 32'd999999999, 32'd1000000000,
                          32'd1000000001, 32'd4000000000, 32'd4294967294, 32'hFFFF_FFFF,
                          32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'd10000,
                          32'd99999, 32'd7, 32'd2147483647};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, zero, full ten-digit runs, digit-count boundaries
      foreach (directed_values[i]) send_number(directed_values[i]);
      drain_digits();

      // Random: three pacing phases, settling in between
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 70 : 0;
         recv_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 33 : 0;
         for (int n = 0; n < RANDOM_PER_PHASE; n++) send_number(pick_number());
         drain_digits();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Converted %0d numbers into %0d checked digits", numbers_sent, checked_digits);
      $display("Covered zero, 32-bit extremes, every digit count and three pacing modes");
      if (error_count == 0 && pending_digits == 0) begin
         $display("Verification passed");
      end else begin
         $display("Mismatches: %0d, digits still owed: %0d", error_count, pending_digits);
         $display("Verification failed");
      end
      $finish;
   end

endmodule
